### rtl/dasr_pkg.sv
package dasr_pkg;

  // Fixed field widths of the item, result and configuration channels, and of the arc count.
  localparam int IDX_W  = 6;
  localparam int CMD_W  = 3;
  localparam int ANS_W  = 6;
  localparam int TOT_W  = 12;
  localparam int CNT_W  = 13;
  localparam int STAT_W = 2;
  localparam int VCNT_W = 7;

  localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REACH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OUTDEG = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INDEG  = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_SELF  = 2'd2;

  // Microprogram address.
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Row memory read select.
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_NONE  = 2'd0;
  localparam rd_sel_t RD_SRC   = 2'd1;
  localparam rd_sel_t RD_SWEEP = 2'd2;
  localparam rd_sel_t RD_PICK  = 2'd3;

  // Datapath operation.
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP     = 4'd0;
  localparam op_t OP_OUT     = 4'd1;
  localparam op_t OP_INS     = 4'd2;
  localparam op_t OP_REM     = 4'd3;
  localparam op_t OP_LOAD    = 4'd4;
  localparam op_t OP_ACC_ROW = 4'd5;
  localparam op_t OP_ACC_COL = 4'd6;
  localparam op_t OP_MARK    = 4'd7;
  localparam op_t OP_MERGE   = 4'd8;
  localparam op_t OP_REACH   = 4'd9;

  // Jump condition: when true go to target, otherwise to the next step.
  typedef logic [1:0] cond_t;
  localparam cond_t C_NEXT       = 2'd0;
  localparam cond_t C_ALWAYS     = 2'd1;
  localparam cond_t C_U_MORE     = 2'd2;
  localparam cond_t C_REACH_DONE = 2'd3;

  typedef struct packed {
    rd_sel_t rd;
    op_t     op;
    cond_t   cond;
    upc_t    target;
  } ctrl_t;

  typedef struct packed {
    logic u_more;
    logic reach_done;
    logic out_hold;
  } flags_t;

  localparam ctrl_t CTRL_IDLE = '{RD_NONE, OP_NOP, C_NEXT, 4'd0};

  // Microprogram step addresses, the routine entry points among them.
  localparam upc_t U_OUT      = 4'd0;
  localparam upc_t U_INS      = 4'd1;
  localparam upc_t U_INS_WR   = 4'd2;
  localparam upc_t U_REM      = 4'd3;
  localparam upc_t U_REM_WR   = 4'd4;
  localparam upc_t U_ODG      = 4'd5;
  localparam upc_t U_ODG_LD   = 4'd6;
  localparam upc_t U_ODG_ACC  = 4'd7;
  localparam upc_t U_ODG_END  = 4'd8;
  localparam upc_t U_IDG      = 4'd9;
  localparam upc_t U_IDG_ACC  = 4'd10;
  localparam upc_t U_IDG_END  = 4'd11;
  localparam upc_t U_RCH      = 4'd12;
  localparam upc_t U_RCH_MRG  = 4'd13;
  localparam upc_t U_RCH_FIN  = 4'd14;

  // The control store.
  function automatic ctrl_t ucode(input upc_t a);
    ctrl_t w;
    case (a)
      U_OUT:     w = '{RD_NONE,  OP_OUT,     C_NEXT,       U_OUT};
      U_INS:     w = '{RD_SRC,   OP_NOP,     C_NEXT,       U_OUT};
      U_INS_WR:  w = '{RD_NONE,  OP_INS,     C_ALWAYS,     U_OUT};
      U_REM:     w = '{RD_SRC,   OP_NOP,     C_NEXT,       U_OUT};
      U_REM_WR:  w = '{RD_NONE,  OP_REM,     C_ALWAYS,     U_OUT};
      U_ODG:     w = '{RD_SRC,   OP_NOP,     C_NEXT,       U_OUT};
      U_ODG_LD:  w = '{RD_NONE,  OP_LOAD,    C_NEXT,       U_OUT};
      U_ODG_ACC: w = '{RD_NONE,  OP_ACC_ROW, C_U_MORE,     U_ODG_ACC};
      U_ODG_END: w = '{RD_NONE,  OP_NOP,     C_ALWAYS,     U_OUT};
      U_IDG:     w = '{RD_SWEEP, OP_NOP,     C_NEXT,       U_OUT};
      U_IDG_ACC: w = '{RD_NONE,  OP_ACC_COL, C_U_MORE,     U_IDG};
      U_IDG_END: w = '{RD_NONE,  OP_NOP,     C_ALWAYS,     U_OUT};
      U_RCH:     w = '{RD_PICK,  OP_MARK,    C_REACH_DONE, U_RCH_FIN};
      U_RCH_MRG: w = '{RD_NONE,  OP_MERGE,   C_ALWAYS,     U_RCH};
      U_RCH_FIN: w = '{RD_NONE,  OP_REACH,   C_ALWAYS,     U_OUT};
      default:   w = '{RD_NONE,  OP_NOP,     C_ALWAYS,     U_OUT};
    endcase
    return w;
  endfunction

  // Dispatch of an accepted item to its routine.
  function automatic upc_t entry_of(input logic [CMD_W-1:0] c, input logic fault);
    upc_t e;
    if (fault) begin
      e = U_OUT;
    end else begin
      case (c)
        CMD_INSERT: e = U_INS;
        CMD_REMOVE: e = U_REM;
        CMD_REACH:  e = U_RCH;
        CMD_OUTDEG: e = U_ODG;
        CMD_INDEG:  e = U_IDG;
        default:    e = U_OUT;
      endcase
    end
    return e;
  endfunction

endpackage

### rtl/digraph_arc_store_reachability.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_stall      cmd, src_vertex, dst_vertex
// out       output     out_valid / out_stall    answer, arc_total, status
// cfg       input      cfg_valid / cfg_ready    cfg_vertex_count
//
// Items are worked one at a time by a short microprogram. The time to the
// next input transfer grows with the vertices in use for out-degree,
// in-degree and reach; the one read port of the row memory sets this.
// Synchronous reset empties the graph at once through per-row valid bits.
// A stalled result holds while the next item is worked, then blocks its end.
module digraph_arc_store_reachability
  import dasr_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [IDX_W-1:0]  src_vertex,
  input  logic [IDX_W-1:0]  dst_vertex,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ANS_W-1:0]  answer,
  output logic [TOT_W-1:0]  arc_total,
  output logic [STAT_W-1:0] status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [VCNT_W-1:0] cfg_vertex_count
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  logic                    busy;
  logic                    in_accept;
  ctrl_t                   ctrl;
  flags_t                  flags;
  upc_t                    entry;
  logic                    ram_we;
  logic [VW-1:0]           ram_waddr;
  logic [MAX_VERTICES-1:0] ram_wdata;
  logic                    ram_re;
  logic [VW-1:0]           ram_raddr;
  logic [MAX_VERTICES-1:0] ram_rdata;

  // The sequencer owns the whole item, so input is held off while it runs.
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  // The vertex count is only rewritten between items.
  assign cfg_ready = !busy;

  dasr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .entry     (entry),
    .flags     (flags),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  dasr_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .in_accept        (in_accept),
    .cmd              (cmd),
    .src_vertex       (src_vertex),
    .dst_vertex       (dst_vertex),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_vertex_count (cfg_vertex_count),
    .out_stall        (out_stall),
    .entry            (entry),
    .flags            (flags),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .answer           (answer),
    .arc_total        (arc_total),
    .status           (status)
  );

  // One row of arc bits per tail vertex.
  dasr_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### rtl/dasr_ram.sv
module dasr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/dasr_seq.sv
module dasr_seq
  import dasr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_accept,
  input  upc_t   entry,
  input  flags_t flags,
  output logic   busy,
  output ctrl_t  ctrl
);

  upc_t  upc;
  ctrl_t word;
  logic  jump;

  always_comb begin
    word = ucode(upc);
    case (word.cond)
      C_ALWAYS:     jump = 1'b1;
      C_U_MORE:     jump = flags.u_more;
      C_REACH_DONE: jump = flags.reach_done;
      default:      jump = 1'b0;
    endcase
    ctrl = busy ? word : CTRL_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= U_OUT;
    end else if (!busy) begin
      if (in_accept) begin
        busy <= 1'b1;
        upc  <= entry;
      end
    end else if (word.op == OP_OUT) begin
      // The result step waits here until the output register is free.
      if (!flags.out_hold) begin
        busy <= 1'b0;
      end
    end else begin
      upc <= jump ? word.target : upc_t'(upc + 1'b1);
    end
  end

endmodule

### rtl/dasr_dpath.sv
module dasr_dpath
  import dasr_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_t                   ctrl,
  input  logic                    in_accept,
  input  logic [CMD_W-1:0]        cmd,
  input  logic [IDX_W-1:0]        src_vertex,
  input  logic [IDX_W-1:0]        dst_vertex,
  input  logic                    cfg_we,
  input  logic [VCNT_W-1:0]       cfg_vertex_count,
  input  logic                    out_stall,
  output upc_t                    entry,
  output flags_t                  flags,
  output logic                    ram_we,
  output logic [VW-1:0]           ram_waddr,
  output logic [MAX_VERTICES-1:0] ram_wdata,
  output logic                    ram_re,
  output logic [VW-1:0]           ram_raddr,
  input  logic [MAX_VERTICES-1:0] ram_rdata,
  output logic                    out_valid,
  output logic [ANS_W-1:0]        answer,
  output logic [TOT_W-1:0]        arc_total,
  output logic [STAT_W-1:0]       status
);

  localparam int LW      = $clog2(MAX_VERTICES + 1);
  localparam int CW      = (LW > IDX_W) ? LW : IDX_W;
  localparam int CMPW    = (LW > VCNT_W) ? LW : VCNT_W;
  localparam int LIM_RST = (MAX_VERTICES < int'(VCOUNT_RESET)) ?
                           MAX_VERTICES : int'(VCOUNT_RESET);

  logic [LW-1:0]           lim;
  logic [LW-1:0]           lim_new;
  logic [MAX_VERTICES-1:0] mask;
  logic [MAX_VERTICES-1:0] vld;
  logic                    vld_q;
  logic [MAX_VERTICES-1:0] row;
  logic [MAX_VERTICES-1:0] row_reg;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] done;
  logic [MAX_VERTICES-1:0] pend;
  logic [MAX_VERTICES-1:0] low;
  logic [MAX_VERTICES-1:0] tbit;
  logic [VW-1:0]           pick;
  logic [VW-1:0]           s_idx;
  logic [VW-1:0]           t_idx;
  logic [VW-1:0]           u_idx;
  logic [LW-1:0]           u;
  logic [LW-1:0]           acc;
  logic [STAT_W-1:0]       status_r;
  logic [STAT_W-1:0]       st_new;
  logic [CNT_W-1:0]        arc_cnt;
  logic                    s_ok;
  logic                    t_ok;
  logic                    bit_t;
  logic                    out_load;

  // Classification of the incoming item.
  always_comb begin
    s_ok = CW'(src_vertex) < CW'(lim);
    t_ok = CW'(dst_vertex) < CW'(lim);
    case (cmd)
      CMD_INSERT: st_new = !(s_ok && t_ok) ? STATUS_RANGE :
                           (src_vertex == dst_vertex) ? STATUS_SELF : STATUS_OK;
      CMD_REMOVE,
      CMD_REACH:  st_new = (s_ok && t_ok) ? STATUS_OK : STATUS_RANGE;
      CMD_OUTDEG: st_new = s_ok ? STATUS_OK : STATUS_RANGE;
      CMD_INDEG:  st_new = t_ok ? STATUS_OK : STATUS_RANGE;
      default:    st_new = STATUS_OK;
    endcase
    entry = entry_of(cmd, st_new != STATUS_OK);
  end

  // A row that was never written reads as empty.
  assign row   = vld_q ? ram_rdata : '0;
  assign tbit  = MAX_VERTICES'(1) << t_idx;
  assign bit_t = row[t_idx];
  assign u_idx = u[VW-1:0];

  // Lowest vertex that is reached but not yet expanded.
  always_comb begin
    pend = visited & ~done;
    low  = pend & (~pend + MAX_VERTICES'(1));
    pick = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (low[i]) begin
        pick = pick | VW'(i);
      end
    end
  end

  always_comb begin
    flags.u_more     = ({1'b0, u} + 1'b1) < {1'b0, lim};
    flags.reach_done = (pend == '0) || visited[t_idx];
    flags.out_hold   = out_valid && out_stall;
    out_load         = (ctrl.op == OP_OUT) && !flags.out_hold;
  end

  always_comb begin
    ram_we    = ((ctrl.op == OP_INS) && !bit_t) || ((ctrl.op == OP_REM) && bit_t);
    ram_waddr = s_idx;
    ram_wdata = (ctrl.op == OP_INS) ? (row | tbit) : (row & ~tbit);
    ram_re    = ctrl.rd != RD_NONE;
    case (ctrl.rd)
      RD_SWEEP: ram_raddr = u_idx;
      RD_PICK:  ram_raddr = pick;
      default:  ram_raddr = s_idx;
    endcase
  end

  always_comb begin
    if (CMPW'(cfg_vertex_count) >= CMPW'(MAX_VERTICES)) begin
      lim_new = LW'(MAX_VERTICES);
    end else begin
      lim_new = LW'(cfg_vertex_count);
    end
  end

  // Configuration, arc count and row valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      lim     <= LW'(LIM_RST);
      for (int i = 0; i < MAX_VERTICES; i++) begin
        mask[i] <= i < LIM_RST;
      end
      vld     <= '0;
      vld_q   <= 1'b0;
      arc_cnt <= '0;
    end else begin
      if (cfg_we) begin
        lim <= lim_new;
        for (int i = 0; i < MAX_VERTICES; i++) begin
          mask[i] <= CMPW'(i) < CMPW'(lim_new);
        end
      end
      if (ram_we) begin
        vld[s_idx] <= 1'b1;
      end
      if (ram_re) begin
        vld_q <= vld[ram_raddr];
      end
      if (ctrl.op == OP_INS && !bit_t) begin
        arc_cnt <= arc_cnt + 1'b1;
      end else if (ctrl.op == OP_REM && bit_t) begin
        arc_cnt <= arc_cnt - 1'b1;
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_idx    <= VW'(src_vertex);
      t_idx    <= VW'(dst_vertex);
      status_r <= st_new;
      acc      <= '0;
      u        <= '0;
      visited  <= MAX_VERTICES'(1) << VW'(src_vertex);
      done     <= '0;
    end else begin
      case (ctrl.op)
        OP_LOAD:    row_reg <= row;
        OP_ACC_ROW: begin
          acc <= acc + LW'(row_reg[u_idx]);
          u   <= u + 1'b1;
        end
        OP_ACC_COL: begin
          acc <= acc + LW'(bit_t);
          u   <= u + 1'b1;
        end
        OP_MARK:    done    <= done | low;
        OP_MERGE:   visited <= visited | (row & mask);
        OP_REACH:   acc     <= LW'(visited[t_idx]);
        default:    ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      answer    <= ANS_W'(acc);
      arc_total <= arc_cnt[TOT_W-1:0];
      status    <= status_r;
    end
  end

endmodule

### rtl/dasr_check.sv
module dasr_check
  import dasr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ANS_W-1:0]  answer,
  input logic [TOT_W-1:0]  arc_total,
  input logic [STAT_W-1:0] status
);

  // Reset leaves the block empty and ready for a transfer.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // An accepted item keeps the input held off while it is worked.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after a transfer");

  // A flagged result never carries an answer, and no status code beyond the set.
  a_flag_answer: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> answer == '0 &&
      (status == STATUS_RANGE || status == STATUS_SELF))
    else $error("flagged result with nonzero answer or bad status");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(answer) &&
      $stable(arc_total) && $stable(status))
    else $error("stalled result changed");

endmodule

bind digraph_arc_store_reachability dasr_check u_check (.*);
